### rtl/fan_puff_and_flap_driver_core_macros.svh
`ifndef FAN_PUFF_AND_FLAP_DRIVER_CORE_MACROS_SVH
`define FAN_PUFF_AND_FLAP_DRIVER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FPFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpfd_pkg.sv
`timescale 1ns / 1ps

package fpfd_pkg;

    localparam int DemandW  = 9;
    localparam int TimeW    = 32;
    localparam int PctW     = 7;
    localparam int MsW      = 22;
    localparam int DutyW    = 10;
    localparam int PhaseW   = 2;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    localparam logic [PhaseW-1:0] PhaseIdle = 2'd0;
    localparam logic [PhaseW-1:0] PhasePuff = 2'd1;
    localparam logic [PhaseW-1:0] PhaseRest = 2'd2;

    localparam logic [CfgIdxW-1:0] CfgMaxFan = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPuff   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgRest   = 2'd2;

    localparam logic [DutyW-1:0] FanOff = 10'd1023;

    localparam logic [PctW-1:0] MaxFanReset = 7'd100;
    localparam logic [MsW-1:0]  PuffReset   = 22'd6000;
    localparam logic [MsW-1:0]  RestReset   = 22'd20000;

    // floor(x/100) = (x * Recip100) >> 24 for x below 2^17
    localparam logic [63:0] Recip100Full = ((64'd1 << 24) + 64'd99) / 64'd100;
    localparam logic [17:0] Recip100     = Recip100Full[17:0];
    localparam int          Recip100Sh   = 24;

    // floor(p*340659/1e6) = (p * FlapMul) >> 31 for p below 2^11
    localparam logic [63:0] FlapMulFull =
        (64'd340659 * (64'd1 << 31) + 64'd999999) / 64'd1000000;
    localparam logic [29:0] FlapMul   = FlapMulFull[29:0];
    localparam int          FlapMulSh = 31;

    typedef struct packed {
        logic load;
        logic step2;
        logic step3;
        logic commit;
    } cmd_t;

endpackage

### rtl/fpfd_ctrl.sv
`timescale 1ns / 1ps

module fpfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output fpfd_pkg::cmd_t   cmd
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StMul    = 2'd1;
    localparam logic [1:0] StProd   = 2'd2;
    localparam logic [1:0] StCommit = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = StMul;
                end
            end
            StMul:
            begin
                cmd.step2  = 1'b1;
                state_next = StProd;
            end
            StProd:
            begin
                cmd.step3  = 1'b1;
                state_next = StCommit;
            end
            StCommit:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    assign out_valid_next = cmd.commit | (out_valid_reg & ~m_tready);
    assign s_tready       = (state_reg == StIdle);
    assign m_tvalid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/fpfd_dp.sv
`timescale 1ns / 1ps

module fpfd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpfd_pkg::cmd_t                  cmd,
    input  logic                            cfg_we,
    input  logic [fpfd_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [fpfd_pkg::MsW-1:0]        cfg_data,
    input  logic [fpfd_pkg::InDataW-1:0]    in_data,
    output logic [fpfd_pkg::OutDataW-1:0]   out_data
);

    logic [fpfd_pkg::PctW-1:0]   max_pct_reg;
    logic [fpfd_pkg::MsW-1:0]    puff_ms_reg;
    logic [fpfd_pkg::MsW-1:0]    rest_ms_reg;

    logic [fpfd_pkg::PhaseW-1:0] phase_reg;
    logic [fpfd_pkg::PhaseW-1:0] phase_next;
    logic [fpfd_pkg::TimeW-1:0]  cycle_start_reg;
    logic [fpfd_pkg::TimeW-1:0]  cycle_start_next;
    logic [fpfd_pkg::DutyW-1:0]  fan_level_reg;
    logic [fpfd_pkg::DutyW-1:0]  fan_level_next;

    logic [fpfd_pkg::DemandW-1:0] demand_reg;
    logic [fpfd_pkg::TimeW-1:0]   now_reg;
    logic [fpfd_pkg::TimeW-1:0]   elapsed_reg;
    logic [fpfd_pkg::MsW:0]       total_reg;
    logic                         ge_puff_reg;
    logic                         ge_total_reg;
    logic [16:0]                  pct_x_reg;
    logic [10:0]                  pulse_reg;
    logic [15:0]                  num_reg;
    logic [fpfd_pkg::DutyW-1:0]   m_reg;
    logic [fpfd_pkg::DutyW-1:0]   flap_reg;
    logic [25:0]                  prod_reg;

    logic [fpfd_pkg::DutyW-1:0]   fan_out_reg;
    logic [fpfd_pkg::DutyW-1:0]   flap_out_reg;
    logic [fpfd_pkg::PhaseW-1:0]  phase_out_reg;

    logic [fpfd_pkg::DemandW-1:0] demand_in;
    logic [fpfd_pkg::TimeW-1:0]   now_in;
    logic [fpfd_pkg::PctW-1:0]    pct;
    logic [fpfd_pkg::DemandW-1:0] clip;
    logic [17:0]                  clip_scaled;
    logic [fpfd_pkg::DemandW-1:0] demand_ofs;
    logic [34:0]                  m_prod;
    logic [40:0]                  flap_prod;
    logic [17:0]                  speed_in;
    logic [35:0]                  speed_prod;
    logic [fpfd_pkg::DutyW-1:0]   speed_raw;
    logic [fpfd_pkg::DutyW-1:0]   speed;
    logic                         demand_hi;
    logic                         demand_lo;

    assign demand_in = in_data[fpfd_pkg::DemandW-1:0];
    assign now_in    = in_data[fpfd_pkg::DemandW +: fpfd_pkg::TimeW];

    assign pct  = (max_pct_reg > 7'd100) ? 7'd100 : max_pct_reg;
    assign clip = (demand_in > 9'd256) ? 9'd256 : demand_in;
    assign clip_scaled = 18'(clip) * 18'd715 + 18'd255;
    assign demand_ofs  = demand_in - 9'd255;

    assign m_prod    = 35'(pct_x_reg) * 35'(fpfd_pkg::Recip100);
    assign flap_prod = 41'(pulse_reg) * 41'(fpfd_pkg::FlapMul);

    assign speed_in   = prod_reg[25:8];
    assign speed_prod = 36'(speed_in) * 36'(fpfd_pkg::Recip100);
    assign speed_raw  = speed_prod[fpfd_pkg::Recip100Sh +: fpfd_pkg::DutyW];
    assign speed      = (speed_raw > m_reg) ? m_reg : speed_raw;

    assign demand_hi = (demand_reg > 9'd255);
    assign demand_lo = (demand_reg < 9'd255);

    always_comb
    begin
        phase_next       = phase_reg;
        cycle_start_next = cycle_start_reg;
        fan_level_next   = fan_level_reg;
        unique case (phase_reg)
            fpfd_pkg::PhasePuff:
            begin
                if (ge_puff_reg)
                begin
                    phase_next     = fpfd_pkg::PhaseRest;
                    fan_level_next = fpfd_pkg::FanOff;
                end
            end
            fpfd_pkg::PhaseRest:
            begin
                if (ge_total_reg)
                begin
                    phase_next = fpfd_pkg::PhaseIdle;
                end
            end
            default:
            begin
                phase_next = fpfd_pkg::PhaseIdle;
                if (demand_hi)
                begin
                    phase_next       = fpfd_pkg::PhasePuff;
                    cycle_start_next = now_reg;
                    fan_level_next   = fpfd_pkg::FanOff - speed;
                end
            end
        endcase
        // abort on low demand
        if (demand_lo && (phase_next != fpfd_pkg::PhaseIdle))
        begin
            phase_next     = fpfd_pkg::PhaseIdle;
            fan_level_next = fpfd_pkg::FanOff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pct_reg     <= fpfd_pkg::MaxFanReset;
            puff_ms_reg     <= fpfd_pkg::PuffReset;
            rest_ms_reg     <= fpfd_pkg::RestReset;
            phase_reg       <= fpfd_pkg::PhaseIdle;
            cycle_start_reg <= '0;
            fan_level_reg   <= fpfd_pkg::FanOff;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpfd_pkg::CfgMaxFan: max_pct_reg <= cfg_data[fpfd_pkg::PctW-1:0];
                    fpfd_pkg::CfgPuff:   puff_ms_reg <= cfg_data;
                    fpfd_pkg::CfgRest:   rest_ms_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                phase_reg       <= phase_next;
                cycle_start_reg <= cycle_start_next;
                fan_level_reg   <= fan_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            demand_reg  <= demand_in;
            now_reg     <= now_in;
            elapsed_reg <= now_in - cycle_start_reg;
            total_reg   <= {1'b0, puff_ms_reg} + {1'b0, rest_ms_reg};
            pct_x_reg   <= 17'(pct) * 17'd1023;
            pulse_reg   <= 11'd2015 - 11'(clip_scaled[17:8]);
            num_reg     <= 16'd3840 + 16'(demand_ofs) * 16'd85;
        end
        if (cmd.step2)
        begin
            ge_puff_reg  <= (elapsed_reg >= 32'(puff_ms_reg));
            ge_total_reg <= (elapsed_reg >= 32'(total_reg));
            m_reg        <= m_prod[fpfd_pkg::Recip100Sh +: fpfd_pkg::DutyW];
            flap_reg     <= flap_prod[fpfd_pkg::FlapMulSh +: fpfd_pkg::DutyW];
        end
        if (cmd.step3)
        begin
            prod_reg <= 26'(m_reg) * 26'(num_reg);
        end
        if (cmd.commit)
        begin
            fan_out_reg   <= fan_level_next;
            flap_out_reg  <= flap_reg;
            phase_out_reg <= phase_next;
        end
    end

    assign out_data = {2'b00, phase_out_reg, flap_out_reg, fan_out_reg};

endmodule

### rtl/fan_puff_and_flap_driver_core.sv
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// s_*       | in        | s_tvalid/s_tready  | s_tdata: demand[8:0], now_ms[40:9]
// m_*       | out       | m_tvalid/m_tready  | m_tdata: fan_duty, flap_duty, fan_phase
// cfg_*     | in        | cfg_we             | cfg_index, cfg_data
//
// One transaction in gives one transaction out; each item passes through the
// chain of load, two multiply steps and the state commit.
// s_tready is high only while the sequencer is idle.
// The output register lets the next input be taken while a result waits.
// A stalled output holds the commit step until m_tready frees the register.
// rst_n clears the fan state to idle, fan off, and loads register defaults.

module fan_puff_and_flap_driver_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [8:0] demand, [40:9] now_ms, [47:41] zero
    input  logic [fpfd_pkg::InDataW-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] fan_duty, [19:10] flap_duty, [21:20] fan_phase, [23:22] zero
    output logic [fpfd_pkg::OutDataW-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [fpfd_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [fpfd_pkg::MsW-1:0]        cfg_data
);

    fpfd_pkg::cmd_t cmd;

    fpfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fpfd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

endmodule

### rtl/fpfd_checker.sv
`timescale 1ns / 1ps
`include "fan_puff_and_flap_driver_core_macros.svh"

module fpfd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fpfd_pkg::OutDataW-1:0]   m_tdata
);

    logic [fpfd_pkg::DutyW-1:0]  fan_duty;
    logic [fpfd_pkg::DutyW-1:0]  flap_duty;
    logic [fpfd_pkg::PhaseW-1:0] fan_phase;
    logic                        in_xfer;
    logic                        not_puff;
    logic                        fan_off;
    logic                        flap_ok;
    logic                        out_stall;

    assign fan_duty  = m_tdata[9:0];
    assign flap_duty = m_tdata[19:10];
    assign fan_phase = m_tdata[21:20];
    assign in_xfer   = s_tvalid && s_tready;
    assign not_puff  = m_tvalid && (fan_phase != fpfd_pkg::PhasePuff);
    assign fan_off   = (fan_duty == fpfd_pkg::FanOff);
    assign flap_ok   = (flap_duty >= 10'd442) && (flap_duty <= 10'd686);
    assign out_stall = m_tvalid && !m_tready;

    `FPFD_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_tready, "input taken while busy")
    `FPFD_ASSERT_NOW(a_fan_off_unless_puff, not_puff, fan_off, "fan driven outside puff")
    `FPFD_ASSERT_NOW(a_flap_range, m_tvalid, flap_ok, "flap duty out of range")
    `FPFD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind fan_puff_and_flap_driver_core fpfd_checker u_fpfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fpfd_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
    localparam int QuietLimit   = 2000;
    localparam int SettleCycles = 8;
    localparam int PrintCap     = 200;

    typedef struct packed {
        logic [DutyW-1:0]  fan_duty;
        logic [DutyW-1:0]  flap_duty;
        logic [PhaseW-1:0] fan_phase;
    } tick_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [MsW-1:0]      cfg_data;

    logic [PctW-1:0]     pct_reg;
    logic [MsW-1:0]      puff_reg;
    logic [MsW-1:0]      rest_reg;
    logic [PhaseW-1:0]   fan_phase;
    logic [TimeW-1:0]    cycle_start;
    logic [DutyW-1:0]    fan_level;

    tick_result_t        tick_q[$];
    int                  errors = 0;
    int                  quiet_cycles;
    bit                  idling = 1'b1;
    logic [TimeW-1:0]    stamp;

    fan_puff_and_flap_driver_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [DutyW-1:0] flap_duty_for(logic [DemandW-1:0] demand);
        logic [31:0] travel;
        logic [31:0] pulse;
        logic [63:0] scaled;
        travel = (demand > 256) ? 32'd256 : 32'(demand);
        pulse  = 32'd2015 - ((travel * 32'd715 + 32'd255) >> 8);
        scaled = (64'(pulse) * 64'd340659) / 64'd1000000;
        return scaled[DutyW-1:0];
    endfunction

    function automatic logic [DutyW-1:0] puff_level_for(logic [DemandW-1:0] demand);
        logic [31:0] pct;
        logic [31:0] ceiling;
        logic [31:0] weight;
        logic [31:0] speed;
        pct     = (pct_reg > 100) ? 32'd100 : 32'(pct_reg);
        ceiling = (32'd1023 * pct) / 32'd100;
        weight  = 32'd3840 + 32'd85 * (32'(demand) - 32'd255);
        speed   = (ceiling * weight) / 32'd25600;
        if (speed > ceiling)
        begin
            speed = ceiling;
        end
        return DutyW'(32'd1023 - speed);
    endfunction

    function automatic tick_result_t advance_fan(logic [DemandW-1:0] demand,
                                                 logic [TimeW-1:0] now);
        logic [TimeW-1:0] elapsed;
        logic [TimeW:0]   rest_end;
        tick_result_t     res;
        elapsed  = now - cycle_start;
        rest_end = {11'd0, puff_reg} + {11'd0, rest_reg};
        case (fan_phase)
            PhasePuff:
            begin
                if (elapsed >= {10'd0, puff_reg})
                begin
                    fan_phase = PhaseRest;
                    fan_level = FanOff;
                end
            end
            PhaseRest:
            begin
                if ({1'b0, elapsed} >= rest_end)
                begin
                    fan_phase = PhaseIdle;
                end
            end
            default:
            begin
                fan_phase = PhaseIdle;
                if (demand > 255)
                begin
                    fan_phase   = PhasePuff;
                    cycle_start = now;
                    fan_level   = puff_level_for(demand);
                end
            end
        endcase
        // abort after the phase update of the same tick
        if (demand < 255 && fan_phase != PhaseIdle)
        begin
            fan_phase = PhaseIdle;
            fan_level = FanOff;
        end
        res.fan_duty  = fan_level;
        res.flap_duty = flap_duty_for(demand);
        res.fan_phase = fan_phase;
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (errors < PrintCap)
        begin
            $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
        end
        errors++;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] index, logic [MsW-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            CfgMaxFan: pct_reg  = value[PctW-1:0];
            CfgPuff:   puff_reg = value;
            CfgRest:   rest_reg = value;
            default:   ;
        endcase
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (tick_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic send_tick(logic [DemandW-1:0] demand, logic [TimeW-1:0] now);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, now, demand};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        tick_q.push_back(advance_fan(demand, now));
        @(negedge clk);
    endtask

    task automatic test_directed_ticks();
        logic [TimeW-1:0] base;
        base = 32'hFFFF_FF00;
        send_tick(9'd0, 32'd0);
        send_tick(9'd255, 32'd10);
        send_tick(9'd511, base);
        send_tick(9'd255, base + 32'd5999);
        send_tick(9'd300, base + 32'd6000);
        send_tick(9'd255, base + 32'd25999);
        send_tick(9'd256, base + 32'd26000);
        send_tick(9'd256, base + 32'd26001);
        send_tick(9'd254, base + 32'd26002);
        send_tick(9'd400, 32'd100);
        send_tick(9'd300, 32'd6100);
        send_tick(9'd1, 32'd6101);
        send_tick(9'd511, 32'hFFFF_FFFF);
        send_tick(9'd257, 32'd5999);
        send_tick(9'd128, 32'd6000);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(CfgMaxFan, 22'd0);
        write_reg(CfgPuff, 22'd0);
        write_reg(CfgRest, 22'd0);
        send_tick(9'd511, 32'd1000);
        send_tick(9'd300, 32'd1000);
        send_tick(9'd300, 32'd1000);
        send_tick(9'd0, 32'd1000);
        settle();
        // percent above range, with stray upper bits on the bus
        write_reg(CfgMaxFan, {15'h5A5A, 7'd127});
        write_reg(CfgPuff, 22'd3600000);
        write_reg(CfgRest, 22'd3600000);
        write_reg(CfgSpare, 22'h3FFFFF);
        send_tick(9'd256, 32'd5);
        send_tick(9'd511, 32'd3600004);
        send_tick(9'd511, 32'd3600005);
        send_tick(9'd300, 32'd7200004);
        send_tick(9'd300, 32'd7200005);
        send_tick(9'd2, 32'd7200006);
    endtask

    task automatic test_random_traffic(int count);
        int unsigned      pick;
        logic [TimeW-1:0] span;
        logic [DemandW-1:0] demand;
        settle();
        write_reg(CfgMaxFan, 22'($urandom_range(0, 127)));
        write_reg(CfgPuff, 22'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3600000)
                                                            : $urandom_range(0, 200)));
        write_reg(CfgRest, 22'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3600000)
                                                            : $urandom_range(0, 200)));
        stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + 32'($urandom_range(0, 255))
                                            : 32'($urandom);
        span = 32'(puff_reg) + 32'(rest_reg) + 32'd50;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                stamp = stamp + 32'($urandom_range(0, 60));
            else if (pick < 92)
                stamp = stamp + 32'($urandom_range(0, span));
            else if (pick < 96)
                stamp = 32'($urandom);
            else
                stamp = stamp - 32'($urandom_range(1, 32));
            pick = $urandom_range(0, 99);
            if (pick < 75)
                demand = 9'($urandom_range(256, 511));
            else if (pick < 85)
                demand = 9'd255;
            else if (pick < 94)
                demand = 9'($urandom_range(0, 254));
            else
                demand = 9'($urandom_range(0, 511));
            send_tick(demand, stamp);
        end
    endtask

    task automatic test_unthrottled_tail();
        idling = 1'b0;
        test_random_traffic(90);
    endtask

    always @(posedge clk)
    begin : check_results
        tick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tick_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", int'(m_tdata), 0);
            end
            else
            begin
                want = tick_q.pop_front();
                if (m_tdata[9:0] !== want.fan_duty)
                    report_mismatch("fan_duty", int'(m_tdata[9:0]), int'(want.fan_duty));
                if (m_tdata[19:10] !== want.flap_duty)
                    report_mismatch("flap_duty", int'(m_tdata[19:10]), int'(want.flap_duty));
                if (m_tdata[21:20] !== want.fan_phase)
                    report_mismatch("fan_phase", int'(m_tdata[21:20]), int'(want.fan_phase));
            end
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < QuietLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[fan_puff_and_flap_driver_core] ERROR");
        $finish;
    end

    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pct_reg     = MaxFanReset;
        puff_reg    = PuffReset;
        rest_reg    = RestReset;
        fan_phase   = PhaseIdle;
        cycle_start = '0;
        fan_level   = FanOff;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ticks();
        test_register_extremes();
        repeat (6) test_random_traffic(60);
        test_unthrottled_tail();

        settle();
        repeat (12) @(negedge clk);
        if (errors == 0)
            $display("[fan_puff_and_flap_driver_core] OK");
        else
            $display("[fan_puff_and_flap_driver_core] ERROR");
        $finish;
    end

endmodule
